// ===== hdl/sti_pkg.sv =====
package sti_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 4;
  localparam int POS_W = 5;
  localparam int INDEX_SPAN = 1 << INDEX_W;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                       cmd;
    logic signed [VALUE_W-1:0]  value;
    logic [INDEX_W-1:0]         index;
  } sti_in_t;

  typedef struct packed {
    status_t                    status;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  data;
    logic [POS_W-1:0]           fill_count;
  } sti_out_t;

  typedef struct packed {
    logic                       ins;
    logic                       del;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctrl_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

// ===== hdl/sorted_table_insert_delete.sv =====
// Channel   Handshake            Payload    Notes
// command   start in, busy out   command    taken when start is high and busy is low
// result    done out             result     shown for one cycle, cannot be held off
//
// Each transaction is first accepted, which raises busy; while busy is high,
// every cell compares its entry with the value and the whole row shifts at once.
// The result is shown in the cycle after that, when busy is already low again.
// Reset clears the fill count and the handshake flags; entries are not reset.
// The receiver cannot stall, so nothing holds the row back.
module sorted_table_insert_delete #(
  parameter int CAPACITY = sti_pkg::CAPACITY_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sti_pkg::sti_in_t  command,
  output logic              busy,
  output logic              done,
  output sti_pkg::sti_out_t result
);
  import sti_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

  sti_in_t                   cur;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  sti_out_t                  result_next;
  cell_ctrl_t                ctrl;
  logic                      full;
  logic                      found;
  logic [CAPACITY-1:0]       eq_vec;
  logic [CAPACITY-1:0]       slot_vec;
  logic [CAPACITY-1:0]       first_vec;
  logic [CW-1:0]             ins_pos;
  logic [CW-1:0]             del_pos;
  logic signed [VALUE_W-1:0] cell_entry [CAPACITY];
  cell_flags_t               cell_flags [CAPACITY];
  logic signed [VALUE_W-1:0] read_window [INDEX_SPAN];
  logic                      index_ok;

  assign full = (count == CW'(CAPACITY));
  assign found = |eq_vec;

  always_comb begin
    ctrl.value = cur.value;
    ctrl.ins = busy && (cur.cmd == CMD_INSERT) && !full;
    ctrl.del = busy && (cur.cmd == CMD_DELETE) && found;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                      occ;
      logic                      p_lt;
      logic signed [VALUE_W-1:0] p_entry;
      logic signed [VALUE_W-1:0] n_entry;

      assign occ = (CW'(gi) < count);
      if (gi == 0) begin : g_first
        assign p_lt = 1'b1;
        assign p_entry = cur.value;
      end else begin : g_mid
        assign p_lt = cell_flags[gi-1].lt;
        assign p_entry = cell_entry[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign n_entry = cell_entry[gi];
      end else begin : g_inner
        assign n_entry = cell_entry[gi+1];
      end

      sti_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .occupied   (occ),
        .prev_lt    (p_lt),
        .prev_entry (p_entry),
        .next_entry (n_entry),
        .entry      (cell_entry[gi]),
        .flags      (cell_flags[gi])
      );

      assign eq_vec[gi] = cell_flags[gi].eq;
      assign slot_vec[gi] = !p_lt ? 1'b0 : !cell_flags[gi].lt;
      if (gi == 0) begin : g_first_eq
        assign first_vec[gi] = cell_flags[gi].eq;
      end else begin : g_next_eq
        assign first_vec[gi] = cell_flags[gi].eq && !cell_flags[gi-1].eq;
      end
    end

    for (gi = 0; gi < INDEX_SPAN; gi++) begin : g_window
      if (gi < CAPACITY) begin : g_live
        assign read_window[gi] = cell_entry[gi];
      end else begin : g_dead
        assign read_window[gi] = '0;
      end
    end
  endgenerate

  always_comb begin
    ins_pos = '0;
    del_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_vec[i]) begin
        ins_pos = ins_pos | CW'(i);
      end
      if (first_vec[i]) begin
        del_pos = del_pos | CW'(i);
      end
    end
  end

  assign index_ok = (CMPW'(cur.index) < CMPW'(count));

  always_comb begin
    count_next = count;
    result_next.status = ST_OK;
    result_next.position = '0;
    result_next.data = '0;
    case (cur.cmd)
      CMD_INSERT: begin
        if (full) begin
          result_next.status = ST_FULL;
        end else begin
          count_next = count + CW'(1);
          result_next.position = POS_W'(ins_pos);
        end
      end
      CMD_DELETE: begin
        if (found) begin
          count_next = count - CW'(1);
          result_next.position = POS_W'(del_pos);
        end else begin
          result_next.status = ST_NOT_FOUND;
        end
      end
      CMD_READ: begin
        result_next.position = POS_W'(cur.index);
        if (index_ok) begin
          result_next.data = read_window[cur.index];
        end else begin
          result_next.status = ST_BAD_INDEX;
        end
      end
      default: begin
      end
    endcase
    result_next.fill_count = POS_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= busy;
      if (busy) begin
        busy <= 1'b0;
        count <= count_next;
      end else if (start) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cur <= command;
    end
    if (busy) begin
      result <= result_next;
    end
  end

endmodule

// ===== hdl/sti_cell.sv =====
module sti_cell (
  input  logic                                clk,
  input  sti_pkg::cell_ctrl_t                 ctrl,
  input  logic                                occupied,
  input  logic                                prev_lt,
  input  logic signed [sti_pkg::VALUE_W-1:0]  prev_entry,
  input  logic signed [sti_pkg::VALUE_W-1:0]  next_entry,
  output logic signed [sti_pkg::VALUE_W-1:0]  entry,
  output sti_pkg::cell_flags_t                flags
);
  import sti_pkg::*;

  assign flags.lt = occupied && (entry < ctrl.value);
  assign flags.eq = occupied && (entry == ctrl.value);

  always_ff @(posedge clk) begin
    if (ctrl.ins && !flags.lt) begin
      entry <= prev_lt ? ctrl.value : prev_entry;
    end else if (ctrl.del && !flags.lt) begin
      entry <= next_entry;
    end
  end

endmodule
